/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ldlpc_pkg.sv */
// ----------------------------------------------------------------------------
// ldlpc_pkg
// Shared types and constants of the Levinson-Durbin LPC solver.
// ----------------------------------------------------------------------------
`default_nettype none
package ldlpc_pkg;
	localparam int MaxOrderDef = 10;
	localparam int OneQ13 = 8192;
	localparam int FracBits = 13;
	localparam int DivSteps = 15;
	localparam int DenShift = 16;
	localparam logic [3:0] OrderReset = 4'd10;
	localparam logic [0:0] RegOrder = 1'b0;

	typedef struct packed {
		logic signed [15:0] corr_value;
		logic corr_last;
	} corr_beat_t;

	typedef struct packed {
		logic signed [15:0] coef_value;
		logic [3:0] coef_index;
		logic coef_last;
		logic truncated;
	} coef_beat_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE, OP_INIT, OP_MAC, OP_RESID, OP_CHECK, OP_DIVINIT, OP_DIVSTEP,
		OP_KSTORE, OP_UPD, OP_EMUL, OP_EUPD, OP_COPY, OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
		logic [4:0] i;
		logic [4:0] j;
	} dp_cmd_t;

	typedef struct packed {
		logic unstable;
		logic big;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/levinson_durbin_lpc_q13.sv */
// ----------------------------------------------------------------------------
// levinson_durbin_lpc_q13
// Fixed-point Levinson-Durbin LPC solver with Q13 coefficients.
// ----------------------------------------------------------------------------
// Usage: pulse start with corr (R[0..p], Q14) one lag per beat while busy is
// low; corr_last marks the last lag. On the last lag busy rises and the
// recursion runs: an init step, then per order i the MAC steps, the residual
// and check steps, the restoring divider with one quotient bit per cycle,
// the update steps and the error-update steps; a saturated divide skips the
// quotient steps, and an unstable step ends the recursion early. Then p
// results come out on coef with coef_strobe high, one per cycle, index 1..p,
// registered from the emit state; busy is low again in the cycle of the last
// result. The receiver cannot stall: each result is valid for exactly one
// cycle. Reset clears the sequencer, coefficient rows, error and lag count
// and sets predictor_order to 10. Configuration goes through the APB port,
// register predictor_order at address 0.
// ----------------------------------------------------------------------------
`default_nettype none
module levinson_durbin_lpc_q13 #(
	parameter int MAX_ORDER = ldlpc_pkg::MaxOrderDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire ldlpc_pkg::corr_beat_t corr,
	output logic coef_strobe,
	output ldlpc_pkg::coef_beat_t coef,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [0:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ldlpc_pkg::*;

	logic [3:0] order_q;
	logic accept;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [4:0] p_eff;

	assign pready = 1'b1;
	assign accept = start && !busy;

	// Hold the order register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) order_q <= OrderReset;
		else if (psel && penable && pwrite && paddr == RegOrder) order_q <= pwdata[3:0];
	end
	assign prdata = (paddr == RegOrder) ? {28'd0, order_q} : 32'd0;

	always_comb begin
		p_eff = {1'b0, order_q};
		if (p_eff == 5'd0) p_eff = 5'd1;
		if (p_eff > 5'(MAX_ORDER)) p_eff = 5'(MAX_ORDER);
	end

	ldlpc_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .frame_go(accept && corr.corr_last),
		.order(order_q), .stat(stat), .cmd(cmd), .busy(busy)
	);

	ldlpc_dp #(.MAX_ORDER(MAX_ORDER)) u_dp (
		.clk(clk), .arst_n(arst_n), .load_en(accept), .load_beat(corr), .cmd(cmd),
		.p(p_eff), .stat(stat), .res_strobe(coef_strobe), .res(coef)
	);
endmodule
`default_nettype wire

/* hw/rtl/ldlpc_ctrl.sv */
// ----------------------------------------------------------------------------
// ldlpc_ctrl
// Sequencer for lag loading, the recursion and coefficient output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ldlpc_ctrl #(
	parameter int MAX_ORDER = ldlpc_pkg::MaxOrderDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic frame_go,
	input wire logic [3:0] order,
	input wire ldlpc_pkg::dp_stat_t stat,
	output ldlpc_pkg::dp_cmd_t cmd,
	output logic busy
);
	import ldlpc_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_MAC = 4'd2,
		S_RESID = 4'd3, S_CHECK = 4'd4, S_DIVI = 4'd5, S_DIV = 4'd6,
		S_KST = 4'd7, S_UPD = 4'd8, S_EMUL = 4'd9, S_EUPD = 4'd10,
		S_COPY = 4'd11, S_EMIT = 4'd12;

	logic [3:0] state_q;
	logic [4:0] i_q, j_q, p_q;
	logic [4:0] p_eff;

	// Clamp the order to the supported range.
	always_comb begin
		p_eff = {1'b0, order};
		if (p_eff == 5'd0) p_eff = 5'd1;
		if (p_eff > 5'(MAX_ORDER)) p_eff = 5'(MAX_ORDER);
	end

	// Step through the recursion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			j_q <= '0;
			p_q <= 5'd1;
		end else begin
			case (state_q)
				S_IDLE: if (frame_go) begin
					state_q <= S_INIT;
					p_q <= p_eff;
				end
				S_INIT: begin
					i_q <= 5'd1;
					j_q <= 5'd1;
					state_q <= S_MAC;
				end
				S_MAC: if (j_q >= i_q) state_q <= S_RESID;
					else j_q <= j_q + 5'd1;
				S_RESID: state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.unstable) begin
						state_q <= S_EMIT;
						j_q <= 5'd1;
					end else begin
						state_q <= S_DIVI;
						j_q <= '0;
					end
				end
				S_DIVI: state_q <= stat.big ? S_KST : S_DIV;
				S_DIV: begin
					if (j_q == 5'(DivSteps - 1)) state_q <= S_KST;
					j_q <= j_q + 5'd1;
				end
				S_KST: begin
					state_q <= S_UPD;
					j_q <= 5'd1;
				end
				S_UPD: if (j_q >= i_q) state_q <= S_EMUL;
					else j_q <= j_q + 5'd1;
				S_EMUL: state_q <= S_EUPD;
				S_EUPD: state_q <= S_COPY;
				S_COPY: begin
					j_q <= 5'd1;
					if (i_q >= p_q) state_q <= S_EMIT;
					else begin
						i_q <= i_q + 5'd1;
						state_q <= S_MAC;
					end
				end
				S_EMIT: begin
					if (j_q >= p_q) state_q <= S_IDLE;
					j_q <= j_q + 5'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Decode the command for the datapath.
	always_comb begin
		cmd.i = i_q;
		cmd.j = j_q;
		case (state_q)
			S_INIT: cmd.op = OP_INIT;
			S_MAC: cmd.op = (j_q < i_q) ? OP_MAC : OP_NONE;
			S_RESID: cmd.op = OP_RESID;
			S_CHECK: cmd.op = OP_CHECK;
			S_DIVI: cmd.op = OP_DIVINIT;
			S_DIV: cmd.op = OP_DIVSTEP;
			S_KST: cmd.op = OP_KSTORE;
			S_UPD: cmd.op = (j_q < i_q) ? OP_UPD : OP_NONE;
			S_EMUL: cmd.op = OP_EMUL;
			S_EUPD: cmd.op = OP_EUPD;
			S_COPY: cmd.op = OP_COPY;
			S_EMIT: cmd.op = OP_EMIT;
			default: cmd.op = OP_NONE;
		endcase
		cmd.j = (state_q == S_EMIT) ? j_q : j_q;
	end

	assign busy = (state_q != S_IDLE);

	`ASSERT_NEXT(a_go_busy, clk, arst_n, frame_go && !busy, busy, "frame start not taken")
	`ASSERT_IMPL(a_i_range, clk, arst_n, busy && state_q != S_INIT, i_q <= p_q, "order overrun")
	`ASSERT_IMPL(a_emit_j, clk, arst_n, state_q == S_EMIT, j_q >= 5'd1 && j_q <= p_q,
		"emit index out of range")
endmodule
`default_nettype wire

/* hw/rtl/ldlpc_dp.sv */
// ----------------------------------------------------------------------------
// ldlpc_dp
// Lag store, coefficient rows, MAC, divider and error update.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ldlpc_dp #(
	parameter int MAX_ORDER = ldlpc_pkg::MaxOrderDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load_en,
	input wire ldlpc_pkg::corr_beat_t load_beat,
	input wire ldlpc_pkg::dp_cmd_t cmd,
	input wire logic [4:0] p,
	output ldlpc_pkg::dp_stat_t stat,
	output logic res_strobe,
	output ldlpc_pkg::coef_beat_t res
);
	import ldlpc_pkg::*;

	localparam int Depth = MAX_ORDER + 1;
	localparam int IW = $clog2(Depth);

	logic signed [15:0] corr_q [Depth];
	logic signed [15:0] prev_q [Depth];
	logic signed [15:0] cur_q [Depth];
	logic signed [15:0] err_q;
	logic [IW:0] load_cnt_q;
	logic signed [31:0] acc_q;
	logic neg_q, trunc_q, big_q;
	logic signed [31:0] prod_q;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic [14:0] quo_q;
	logic signed [15:0] k_q;
	logic signed [15:0] t_q;
	logic prodv_q;

	logic [IW-1:0] ij, jj, imj;
	logic signed [31:0] mac_prod;
	logic [32:0] rem_sh;
	logic signed [31:0] upd_t;
	logic signed [31:0] kk;
	logic signed [15:0] coef_j;
	logic signed [63:0] resid_abs;
	logic unst_c;

	assign ij = cmd.i[IW-1:0];
	assign jj = cmd.j[IW-1:0];
	assign imj = IW'(cmd.i - cmd.j);
	assign mac_prod = 32'(prev_q[jj] * corr_q[imj]);
	assign rem_sh = {rem_q[31:0], 1'b0};
	assign upd_t = sat32(64'(prev_q[jj]) * OneQ13 - 64'(k_q) * 64'(prev_q[imj]));
	assign kk = 32'(k_q * k_q);
	assign coef_j = prev_q[jj];

	// Flag an unstable step from the signed residual held in the accumulator.
	assign resid_abs = (acc_q < 0) ? -64'(acc_q) : 64'(acc_q);
	assign unst_c = (cmd.i > 5'd1) && (resid_abs > 64'(err_q) * OneQ13);

	// Load lags and run the recursion steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			res_strobe <= 1'b0;
			trunc_q <= 1'b0;
			big_q <= 1'b0;
			neg_q <= 1'b0;
			err_q <= '0;
			for (int n = 0; n < Depth; n++) begin
				prev_q[n] <= '0;
				cur_q[n] <= '0;
			end
		end else begin
			res_strobe <= (cmd.op == OP_EMIT);
			if (load_en) begin
				if (load_cnt_q <= (IW+1)'(MAX_ORDER))
					corr_q[load_cnt_q[IW-1:0]] <= load_beat.corr_value;
				if (load_beat.corr_last) load_cnt_q <= '0;
				else if (load_cnt_q <= (IW+1)'(MAX_ORDER)) load_cnt_q <= load_cnt_q + 1'b1;
			end
			case (cmd.op)
				OP_INIT: begin
					for (int n = 0; n < Depth; n++) begin
						prev_q[n] <= '0;
						cur_q[n] <= '0;
					end
					err_q <= corr_q[0];
					trunc_q <= 1'b0;
					acc_q <= '0;
				end
				OP_MAC: prod_q <= mac_prod;
				OP_RESID: acc_q <= sat32(64'(corr_q[ij]) * OneQ13 - 64'(acc_q));
				OP_CHECK: begin
					trunc_q <= unst_c;
					if (acc_q < 0) begin
						neg_q <= 1'b1;
						acc_q <= sat32(-64'(acc_q));
					end else begin
						neg_q <= 1'b0;
					end
				end
				OP_DIVINIT: begin
					rem_q <= {1'b0, sat32(64'(acc_q) * 2)} >> 1;
					den_q <= 33'(64'(err_q) * 65536 >>> 1);
					big_q <= (64'(sat32(64'(acc_q) * 2)) >= 64'(err_q) * 65536);
					quo_q <= '0;
				end
				OP_DIVSTEP: begin
					if ($signed(rem_sh) >= $signed(den_q)) begin
						rem_q <= rem_sh - den_q;
						quo_q <= {quo_q[13:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[13:0], 1'b0};
					end
				end
				OP_KSTORE: begin
					if (big_q) begin
						k_q <= neg_q ? -16'sd32767 : 16'sd32767;
						cur_q[ij] <= neg_q ? -16'sd32767 : 16'sd32767;
					end else begin
						k_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
						cur_q[ij] <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
					end
				end
				OP_UPD: cur_q[jj] <= upd_t[28:13];
				OP_EMUL: t_q <= 16'(sat32(64'(OneQ13) - 64'(kk >>> FracBits)));
				OP_EUPD: err_q <= 16'((32'(err_q) * 32'(t_q)) >>> FracBits);
				OP_COPY: begin
					for (int n = 0; n < Depth; n++) prev_q[n] <= cur_q[n];
					acc_q <= '0;
				end
				OP_EMIT: begin
					res.coef_value <= (coef_j == -16'sd32768) ? 16'sd32767 : -coef_j;
					res.coef_index <= cmd.j[3:0];
					res.coef_last <= (cmd.j == p);
					res.truncated <= trunc_q;
				end
				default: ;
			endcase
			// Accumulate the product from the previous MAC cycle.
			if (cmd.op == OP_MAC && cmd.j > 5'd1 || cmd.op == OP_NONE && cmd.i != 5'd0
				&& cmd.j == cmd.i && cmd.j > 5'd1 && !res_strobe && prodv_q)
				acc_q <= sat32(64'(acc_q) + 64'(prod_q));
		end
	end

	// Mark a pending MAC product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prodv_q <= 1'b0;
		else prodv_q <= (cmd.op == OP_MAC);
	end

	assign stat.unstable = unst_c;
	assign stat.big = (64'(sat32(64'(acc_q) * 2)) >= 64'(err_q) * 65536);

	`ASSERT_NEXT(a_emit_strobe, clk, arst_n, cmd.op == OP_EMIT, res_strobe, "result lost")
	`ASSERT_IMPL(a_load_cnt, clk, arst_n, 1'b1, load_cnt_q <= (IW+1)'(Depth), "load overrun")
	`ASSERT_NEXT(a_init_trunc, clk, arst_n, cmd.op == OP_INIT, !trunc_q, "stale truncate")
endmodule
`default_nettype wire

/* verif/levinson_durbin_lpc_q13_chk.sv */
// ----------------------------------------------------------------------------
// levinson_durbin_lpc_q13_chk
// Watches the lag, coefficient and APB channels of the LPC solver, predicts
// the coefficient beats of every frame with its own fixed-point recursion
// and compares them field by field in order.
// ----------------------------------------------------------------------------
module levinson_durbin_lpc_q13_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input ldlpc_pkg::corr_beat_t corr,
	input logic coef_strobe,
	input ldlpc_pkg::coef_beat_t coef,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [0:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	output int mismatches,
	output int pending,
	output int coefs_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import ldlpc_pkg::*;

	localparam int MaxOrd = MaxOrderDef;

	longint lag_mem [0:MaxOrd];
	int unsigned lag_count;
	logic [3:0] order_reg;
	coef_beat_t coef_due [$];

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint fold16(longint x);
		logic signed [15:0] w;
		w = x[15:0];
		return longint'(w);
	endfunction

	// restoring divide of a nonnegative numerator, 15 quotient bits
	function automatic longint refl_div(longint num, longint den);
		longint d;
		longint q;
		d = den * 65536;
		q = 0;
		if (num >= d) return 32767;
		num = num >>> 1;
		d = d >>> 1;
		for (int s = 0; s < DivSteps; s++) begin
			q = q <<< 1;
			num = num <<< 1;
			if (num >= d) begin
				num = num - d;
				q = q + 1;
			end
		end
		return q;
	endfunction

	// run the recursion on the stored lags and queue the frame's coefficients
	task automatic solve_frame();
		int unsigned ord;
		longint prev [0:MaxOrd];
		longint cur [0:MaxOrd];
		longint err, acc, k, t;
		bit neg, stopped;
		coef_beat_t b;
		ord = order_reg;
		if (ord < 1) ord = 1;
		if (ord > MaxOrd) ord = MaxOrd;
		for (int j = 0; j <= MaxOrd; j++) begin
			prev[j] = 0;
			cur[j] = 0;
		end
		err = lag_mem[0];
		stopped = 0;
		for (int i = 1; i <= ord; i++) begin
			acc = 0;
			neg = 0;
			for (int j = 1; j < i; j++)
				acc = clip32(acc + prev[j] * lag_mem[i - j]);
			acc = clip32(lag_mem[i] * OneQ13 - acc);
			if (acc < 0) begin
				neg = 1;
				acc = clip32(-acc);
			end
			if (i > 1 && acc > err * OneQ13) begin
				stopped = 1;
				break;
			end
			acc = clip32(acc * 2);
			k = refl_div(acc, err);
			if (neg) k = -k;
			cur[i] = k;
			for (int j = 1; j < i; j++) begin
				t = clip32(prev[j] * OneQ13 - k * prev[i - j]);
				cur[j] = fold16(t >>> FracBits);
			end
			t = fold16(clip32(OneQ13 - ((k * k) >>> FracBits)));
			err = fold16((err * t) >>> FracBits);
			prev = cur;
		end
		for (int j = 1; j <= ord; j++) begin
			b.coef_value = (prev[j] == -32768) ? 16'sd32767 : 16'(-prev[j]);
			b.coef_index = 4'(j);
			b.coef_last = (j == ord);
			b.truncated = stopped;
			coef_due.push_back(b);
		end
	endtask

	task automatic flag_mismatch(string what, coef_beat_t exp_b, coef_beat_t got_b);
		if (mismatches < 10)
			$display("%0t: %s: expected val=%0d idx=%0d last=%0d trunc=%0d, got val=%0d idx=%0d last=%0d trunc=%0d",
				$realtime, what, exp_b.coef_value, exp_b.coef_index, exp_b.coef_last,
				exp_b.truncated, got_b.coef_value, got_b.coef_index, got_b.coef_last,
				got_b.truncated);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		coef_beat_t exp_b;
		if (!arst_n) begin
			for (int j = 0; j <= MaxOrd; j++) lag_mem[j] = 0;
			lag_count = 0;
			order_reg = OrderReset;
			coef_due.delete();
			mismatches = 0;
			coefs_seen = 0;
		end else begin
			// track the order register
			if (psel && penable && pwrite && pready && paddr == RegOrder)
				order_reg = pwdata[3:0];
			// compare one coefficient beat against the oldest prediction
			if (coef_strobe) begin
				coefs_seen++;
				if (coef_due.size() == 0) begin
					exp_b = '0;
					flag_mismatch("unexpected coefficient", exp_b, coef);
				end else begin
					exp_b = coef_due.pop_front();
					if (exp_b.coef_value !== coef.coef_value ||
					    exp_b.coef_index !== coef.coef_index ||
					    exp_b.coef_last !== coef.coef_last ||
					    exp_b.truncated !== coef.truncated)
						flag_mismatch("coefficient mismatch", exp_b, coef);
				end
			end
			// store an accepted lag; drop beyond the last slot
			if (start && !busy) begin
				if (lag_count <= MaxOrd) begin
					lag_mem[lag_count] = longint'(corr.corr_value);
					lag_count++;
				end
				if (corr.corr_last) begin
					lag_count = 0;
					solve_frame();
				end
			end
		end
		pending = coef_due.size();
	end
endmodule

/* verif/levinson_durbin_lpc_q13_tb.sv */
// ----------------------------------------------------------------------------
// levinson_durbin_lpc_q13_tb
// Drives frames of autocorrelation lags into the LPC solver under varying
// predictor orders and sender gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module levinson_durbin_lpc_q13_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ldlpc_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	corr_beat_t corr;
	logic coef_strobe;
	coef_beat_t coef;
	logic psel, penable, pwrite;
	logic [0:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int mismatches, pending, coefs_seen;
	int idle_pct;
	int lags_sent, frames_sent;
	int lag_buf [0:12];

	levinson_durbin_lpc_q13 u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .corr(corr),
		.coef_strobe(coef_strobe), .coef(coef), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	levinson_durbin_lpc_q13_chk u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .corr(corr),
		.coef_strobe(coef_strobe), .coef(coef), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .pending(pending), .coefs_seen(coefs_seen)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// write the order register through a setup and an access cycle
	task automatic write_order(int val);
		@(negedge clk);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = RegOrder;
		pwdata = 32'(val);
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	// offer one lag beat, with random gaps, and hold until accepted
	task automatic send_lag(int val, bit last);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 0;
			@(negedge clk);
		end
		start = 1;
		corr.corr_value = 16'(val);
		corr.corr_last = last;
		do @(posedge clk); while (busy);
		lags_sent++;
	endtask

	task automatic send_frame(int n);
		for (int k = 0; k < n; k++) send_lag(lag_buf[k], k == n - 1);
		frames_sent++;
	endtask

	// drain all coefficients before touching the order register
	task automatic wait_idle();
		@(negedge clk);
		start = 0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	// decaying lags shaped like real speech correlation
	task automatic fill_decay(int n);
		int r;
		r = $urandom_range(32767, 1000);
		lag_buf[0] = r;
		for (int k = 1; k < n; k++) begin
			r = (r * int'($urandom_range(32767, 16000))) / 32768;
			if ($urandom_range(9) == 0) r = -r;
			lag_buf[k] = r + int'($urandom_range(64)) - 32;
			if (lag_buf[k] > 32767) lag_buf[k] = 32767;
		end
	endtask

	task automatic fill_noise(int n);
		for (int k = 0; k < n; k++) lag_buf[k] = int'($urandom_range(65535)) - 32768;
	endtask

	task automatic fill_const(int n, int val);
		for (int k = 0; k < n; k++) lag_buf[k] = val;
	endtask

	initial begin
		int ord, eff, n, sel, goal;
		arst_n = 0;
		start = 0;
		corr = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = RegOrder;
		pwdata = '0;
		idle_pct = 16;
		lags_sent = 0;
		frames_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: full frame first so every lag slot holds data
		write_order(10);
		fill_decay(11);
		send_frame(11);
		wait_idle();
		write_order(2);
		fill_const(3, 32767);
		send_frame(3);
		fill_const(3, -32768);
		send_frame(3);
		fill_noise(3);
		lag_buf[0] = 0;
		send_frame(3);
		wait_idle();
		write_order(1);
		fill_decay(2);
		send_frame(2);
		wait_idle();
		write_order(0);
		fill_noise(2);
		send_frame(2);
		wait_idle();
		write_order(15);
		fill_decay(13);
		send_frame(13);
		fill_decay(4);
		send_frame(4);
		wait_idle();
		ord = 15;

		// random frames across three gap profiles
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 16 : (ph == 1) ? 79 : 0;
			goal = lags_sent + 46;
			while (lags_sent < goal) begin
				if ($urandom_range(4) == 0) begin
					wait_idle();
					sel = $urandom_range(5);
					ord = (sel == 0) ? 0 : (sel == 1) ? 15 : (sel == 2) ? 1 :
						(sel == 3) ? 10 : $urandom_range(15);
					write_order(ord);
				end
				eff = (ord < 1) ? 1 : (ord > 10) ? 10 : ord;
				sel = $urandom_range(99);
				if (sel < 70) begin
					n = eff + 1;
					fill_decay(n);
				end else if (sel < 85) begin
					n = eff + 1;
					fill_noise(n);
				end else if (sel < 95) begin
					n = $urandom_range(eff, 1);
					fill_decay(n);
				end else begin
					n = $urandom_range(13, 12);
					fill_decay(n);
				end
				send_frame(n);
			end
		end

		wait_idle();
		repeat (50) @(posedge clk);
		$display("Ran %0d frames, %0d lag beats, %0d coefficient beats checked.",
			frames_sent, lags_sent, coefs_seen);
		$display("Orders 0..15 written, sender gaps of 16, 79 and 0 percent.");
		if (mismatches == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
